FILE: src/spsr_pkg.sv
// spsr_pkg: shared constants for the servo compare-value ramp.
// Opcodes, register indexes, reset values and field widths.
// No dependencies.
`timescale 1ns / 1ps

package spsr_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int NUM_CH            = 3;
	localparam int OUT_POS_BITS      = 16;
	localparam int CFG_BITS          = 8;
	localparam int CNT_BITS          = 8;
	localparam int IN_TDATA_BITS     = 24;
	localparam int OUT_TDATA_BITS    = 56;

	// opcodes
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_SET      = 2'd1;
	localparam logic [1:0] OP_JOG_UP   = 2'd2;
	localparam logic [1:0] OP_JOG_DOWN = 2'd3;

	// register indexes
	localparam logic [2:0] REG_RAMP_STEP     = 3'd0;
	localparam logic [2:0] REG_JOG_STEP      = 3'd1;
	localparam logic [2:0] REG_PERIOD_FIRST  = 3'd2;
	localparam logic [2:0] REG_PERIOD_SECOND = 3'd3;
	localparam logic [2:0] REG_PERIOD_THIRD  = 3'd4;

	// register reset values
	localparam logic [7:0] RAMP_STEP_RST     = 8'd2;
	localparam logic [7:0] JOG_STEP_RST      = 8'd10;
	localparam logic [7:0] PERIOD_FIRST_RST  = 8'd1;
	localparam logic [7:0] PERIOD_SECOND_RST = 8'd2;
	localparam logic [7:0] PERIOD_THIRD_RST  = 8'd1;

endpackage

FILE: src/servo_pwm_slew_ramp.sv
// A request passes through two registers to its result: the input register, then the result register.
// Throughput: one request per cycle while results are taken; all channel updates are done in one pass.
// A new request is taken while a result waits, as long as the input register is free.
// Reset (arst_n low, asynchronous): positions, targets and tick counters clear to zero,
// registers return to ramp_step 2, jog_step 10, periods 1/2/1; both stages empty.
// Depends on spsr_pkg.
`timescale 1ns / 1ps

module servo_pwm_slew_ramp #(
	parameter int POSITION_BITS = spsr_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// command requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // channel[1:0], value[17:2], zero pad
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // position_first, position_second, position_third,
	                              // moving_mask[50:48], zero pad
);

	localparam int PB = POSITION_BITS;
	localparam int NC = spsr_pkg::NUM_CH;

	typedef logic [PB-1:0] pos_t;
	typedef logic [spsr_pkg::CNT_BITS-1:0] cnt_t;

	// configuration registers
	logic [7:0] ramp_step_q;
	logic [7:0] jog_step_q;
	logic [7:0] period_q [NC];

	// channel state
	pos_t positions_q [NC];
	pos_t targets_q   [NC];
	cnt_t counters_q  [NC];

	// input stage
	logic        v_s1;
	logic [1:0]  op_s1;
	logic [1:0]  ch_s1;
	logic [15:0] value_s1;

	// result stage
	logic        out_v_q;
	logic [55:0] out_tdata_q;

	logic advance;
	logic out_free;

	pos_t positions_n [NC];
	pos_t targets_n   [NC];
	cnt_t counters_n  [NC];
	logic [2:0]  mask_n;
	logic [55:0] tdata_n;

	pos_t step_eff;
	pos_t jog_ext;
	pos_t value_ext;

	function automatic pos_t dist_f(input pos_t a, input pos_t b);
		dist_f = (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [15:0] low16_f(input pos_t p);
		logic [PB+15:0] ext;
		ext = {16'b0, p};
		low16_f = ext[15:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign out_free  = !out_v_q || m_tready;
	assign advance   = v_s1 && out_free;
	assign s_tready  = !v_s1 || out_free;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = out_tdata_q;

	always_comb begin
		logic [PB+15:0] vext;
		logic [PB+7:0]  sext;
		logic [PB+7:0]  jext;
		vext      = {{PB{1'b0}}, value_s1};
		sext      = {{PB{1'b0}}, ((ramp_step_q == 8'd0) ? 8'd1 : ramp_step_q)};
		jext      = {{PB{1'b0}}, jog_step_q};
		value_ext = vext[PB-1:0];
		step_eff  = sext[PB-1:0];
		jog_ext   = jext[PB-1:0];
	end

	always_comb begin
		cnt_t cnt_inc;
		cnt_t per;
		for (int c = 0; c < NC; c++) begin
			positions_n[c] = positions_q[c];
			targets_n[c]   = targets_q[c];
			counters_n[c]  = counters_q[c];
		end
		if (op_s1 == spsr_pkg::OP_TICK) begin
			for (int c = 0; c < NC; c++) begin
				per     = (period_q[c] == 8'd0) ? 8'd1 : period_q[c];
				cnt_inc = counters_q[c] + 8'd1;
				if (dist_f(targets_q[c], positions_q[c]) < step_eff) begin
					counters_n[c] = '0;
				end else if (cnt_inc >= per) begin
					counters_n[c] = '0;
					// step cannot overshoot: distance is at least one step
					if (targets_q[c] > positions_q[c]) begin
						positions_n[c] = positions_q[c] + step_eff;
					end else begin
						positions_n[c] = positions_q[c] - step_eff;
					end
				end else begin
					counters_n[c] = cnt_inc;
				end
			end
		end else if (ch_s1 < 2'(NC)) begin
			case (op_s1)
				spsr_pkg::OP_SET: begin
					targets_n[ch_s1] = value_ext;
				end
				spsr_pkg::OP_JOG_UP: begin
					positions_n[ch_s1] = positions_q[ch_s1] + jog_ext;
					targets_n[ch_s1]   = positions_q[ch_s1] + jog_ext;
				end
				spsr_pkg::OP_JOG_DOWN: begin
					positions_n[ch_s1] = positions_q[ch_s1] - jog_ext;
					targets_n[ch_s1]   = positions_q[ch_s1] - jog_ext;
				end
				default: begin
				end
			endcase
		end
		for (int c = 0; c < NC; c++) begin
			mask_n[c] = dist_f(targets_n[c], positions_n[c]) >= step_eff;
		end
		tdata_n = {5'b0, mask_n, low16_f(positions_n[2]), low16_f(positions_n[1]),
			low16_f(positions_n[0])};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q <= spsr_pkg::RAMP_STEP_RST;
			jog_step_q  <= spsr_pkg::JOG_STEP_RST;
			period_q[0] <= spsr_pkg::PERIOD_FIRST_RST;
			period_q[1] <= spsr_pkg::PERIOD_SECOND_RST;
			period_q[2] <= spsr_pkg::PERIOD_THIRD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spsr_pkg::REG_RAMP_STEP:     ramp_step_q <= cfg_data;
				spsr_pkg::REG_JOG_STEP:      jog_step_q  <= cfg_data;
				spsr_pkg::REG_PERIOD_FIRST:  period_q[0] <= cfg_data;
				spsr_pkg::REG_PERIOD_SECOND: period_q[1] <= cfg_data;
				spsr_pkg::REG_PERIOD_THIRD:  period_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NC; c++) begin
				positions_q[c] <= '0;
				targets_q[c]   <= '0;
				counters_q[c]  <= '0;
			end
		end else if (advance) begin
			for (int c = 0; c < NC; c++) begin
				positions_q[c] <= positions_n[c];
				targets_q[c]   <= targets_n[c];
				counters_q[c]  <= counters_n[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser;
			ch_s1    <= s_tdata[1:0];
			value_s1 <= s_tdata[17:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_tdata_q <= tdata_n;
		end
	end

	// input only stalls when both stages are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && out_v_q))
		else $error("input stalled with a free stage");

	// an advancing request always lands in the result register
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_v_q)
		else $error("request lost between stages");

	// a jog leaves the channel parked at its new position
	a_jog_parks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_s1 == spsr_pkg::OP_JOG_UP || op_s1 == spsr_pkg::OP_JOG_DOWN)
			&& ch_s1 < 2'(NC))
		|=> (targets_q[$past(ch_s1)] == positions_q[$past(ch_s1)]))
		else $error("jog left target apart from position");

	// a non-tick request never touches the tick counters
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && op_s1 != spsr_pkg::OP_TICK)
		|=> (counters_q[0] == $past(counters_q[0]) && counters_q[1] == $past(counters_q[1])
			&& counters_q[2] == $past(counters_q[2])))
		else $error("tick counter changed on a command");

endmodule

FILE: tb/tb_servo_pwm_slew_ramp.sv
// tb_servo_pwm_slew_ramp: self-checking bench for the three-channel servo ramp.
// Predicts every result from its own channel model and checks it in request order.
// Depends on spsr_pkg and servo_pwm_slew_ramp.
`timescale 1ns / 1ps

module tb_servo_pwm_slew_ramp;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PRESSURE_HOLD  = 60;

	typedef struct packed {
		logic [2:0]  mask;
		logic [15:0] p2;
		logic [15:0] p1;
		logic [15:0] p0;
	} servo_result_t;

	// channel model and queue of predicted results
	class servo_scoreboard;
		logic [15:0]   pos[3];
		logic [15:0]   tgt[3];
		logic [7:0]    cnt[3];
		logic [7:0]    per[3];
		logic [7:0]    ramp;
		logic [7:0]    jog;
		servo_result_t expq[$];
		int            errors;
		int            n_items;
		int            n_results;
		int            n_moving;

		function new();
			for (int c = 0; c < 3; c++) begin
				pos[c] = '0;
				tgt[c] = '0;
				cnt[c] = '0;
			end
			ramp   = spsr_pkg::RAMP_STEP_RST;
			jog    = spsr_pkg::JOG_STEP_RST;
			per[0] = spsr_pkg::PERIOD_FIRST_RST;
			per[1] = spsr_pkg::PERIOD_SECOND_RST;
			per[2] = spsr_pkg::PERIOD_THIRD_RST;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] d);
			case (idx)
				spsr_pkg::REG_RAMP_STEP:     ramp = d;
				spsr_pkg::REG_JOG_STEP:      jog = d;
				spsr_pkg::REG_PERIOD_FIRST:  per[0] = d;
				spsr_pkg::REG_PERIOD_SECOND: per[1] = d;
				spsr_pkg::REG_PERIOD_THIRD:  per[2] = d;
				default: ;
			endcase
		endfunction

		function logic [15:0] step_size();
			return (ramp == 8'd0) ? 16'd1 : {8'd0, ramp};
		endfunction

		function logic [15:0] gap_of(int c);
			return (tgt[c] >= pos[c]) ? tgt[c] - pos[c] : pos[c] - tgt[c];
		endfunction

		function void note_cmd(logic [1:0] op, logic [1:0] ch, logic [15:0] val);
			servo_result_t r;
			logic [7:0]    p;
			if (op == spsr_pkg::OP_TICK) begin
				for (int c = 0; c < 3; c++) begin
					p = (per[c] == 8'd0) ? 8'd1 : per[c];
					if (gap_of(c) < step_size()) begin
						cnt[c] = '0;
					end else begin
						cnt[c] = cnt[c] + 8'd1;
						if (cnt[c] >= p) begin
							cnt[c] = '0;
							if (tgt[c] > pos[c])
								pos[c] = pos[c] + step_size();
							else
								pos[c] = pos[c] - step_size();
						end
					end
				end
			end else if (ch < 2'd3) begin
				if (op == spsr_pkg::OP_SET) begin
					tgt[ch] = val;
				end else begin
					if (op == spsr_pkg::OP_JOG_UP)
						pos[ch] = pos[ch] + {8'd0, jog};
					else
						pos[ch] = pos[ch] - {8'd0, jog};
					tgt[ch] = pos[ch];
				end
			end
			r.p0 = pos[0];
			r.p1 = pos[1];
			r.p2 = pos[2];
			for (int c = 0; c < 3; c++)
				r.mask[c] = (gap_of(c) >= step_size());
			expq.push_back(r);
			n_items++;
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [55:0] d);
			servo_result_t e;
			servo_result_t g;
			g = d[50:0];
			n_results++;
			if (expq.size() == 0) begin
				report($sformatf("result %h with no request pending", d));
			end else begin
				e = expq.pop_front();
				if (g.mask != 3'd0)
					n_moving++;
				if (g.p0 !== e.p0)
					report($sformatf("position_first got %h exp %h", g.p0, e.p0));
				if (g.p1 !== e.p1)
					report($sformatf("position_second got %h exp %h", g.p1, e.p1));
				if (g.p2 !== e.p2)
					report($sformatf("position_third got %h exp %h", g.p2, e.p2));
				if (g.mask !== e.mask)
					report($sformatf("moving_mask got %b exp %b", g.mask, e.mask));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;

	servo_scoreboard sb;
	bit              idle_en;
	bit              hold_req;
	int              stall_cycles;
	int              n_cfg;

	servo_pwm_slew_ramp u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (PRESSURE_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// handshake monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_cmd(s_tuser, s_tdata[1:0], s_tdata[17:2]);
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
				n_cfg++;
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	task automatic send_cmd(input logic [1:0] op, input logic [1:0] ch,
	                        input logic [15:0] val);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, val, ch};
		do @(posedge clk); while (!s_tready);
	endtask

	// let the monitor note the last accepted request before waiting for the queue to drain
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.expq.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [7:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [7:0] rs, input logic [7:0] js,
	                          input logic [7:0] p0, input logic [7:0] p1,
	                          input logic [7:0] p2);
		wait_idle();
		cfg_write(spsr_pkg::REG_RAMP_STEP, rs);
		cfg_write(spsr_pkg::REG_JOG_STEP, js);
		cfg_write(spsr_pkg::REG_PERIOD_FIRST, p0);
		cfg_write(spsr_pkg::REG_PERIOD_SECOND, p1);
		cfg_write(spsr_pkg::REG_PERIOD_THIRD, p2);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 8'd0;
		if (r < 13)
			return 8'd255;
		return 8'($urandom_range(1, 4));
	endfunction

	task automatic rand_config();
		int         r;
		logic [7:0] rs;
		r = $urandom_range(0, 99);
		rs = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 : 8'($urandom_range(1, 6));
		set_config(rs, 8'($urandom_range(0, 255)), pick_period(), pick_period(), pick_period());
	endtask

	// mostly ticks so ramps run; set targets often land near the current position
	task automatic rand_cmd();
		int          r;
		logic [1:0]  ch;
		logic [15:0] v;
		r  = $urandom_range(0, 99);
		ch = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		v  = 16'($urandom_range(0, 65535));
		if (r < 55) begin
			send_cmd(spsr_pkg::OP_TICK, ch, v);
		end else if (r < 77) begin
			if ($urandom_range(0, 1) && ch != 2'd3)
				v = sb.pos[ch] + 16'($urandom_range(0, 1200)) - 16'd600;
			send_cmd(spsr_pkg::OP_SET, ch, v);
		end else if (r < 88) begin
			send_cmd(spsr_pkg::OP_JOG_UP, ch, v);
		end else begin
			send_cmd(spsr_pkg::OP_JOG_DOWN, ch, v);
		end
	endtask

	initial begin
		sb        = new();
		idle_en   = 1'b1;
		hold_req  = 1'b0;
		n_cfg     = 0;
		stall_cycles = 0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes, residual distance, ignored channel, jog wrap
		send_cmd(spsr_pkg::OP_TICK, 2'd0, 16'h0000);
		send_cmd(spsr_pkg::OP_SET, 2'd0, 16'hFFFF);
		send_cmd(spsr_pkg::OP_SET, 2'd1, 16'd5);
		send_cmd(spsr_pkg::OP_SET, 2'd2, 16'd1);
		repeat (4) send_cmd(spsr_pkg::OP_TICK, 2'd0, 16'h0000);
		send_cmd(spsr_pkg::OP_SET, 2'd3, 16'hAAAA);
		send_cmd(spsr_pkg::OP_JOG_UP, 2'd3, 16'h5555);
		send_cmd(spsr_pkg::OP_JOG_DOWN, 2'd3, 16'h0000);
		send_cmd(spsr_pkg::OP_JOG_DOWN, 2'd2, 16'h0000);
		send_cmd(spsr_pkg::OP_JOG_UP, 2'd0, 16'hFFFF);
		send_cmd(spsr_pkg::OP_SET, 2'd0, 16'h0000);
		send_cmd(spsr_pkg::OP_SET, 2'd1, 16'h5555);
		repeat (3) send_cmd(spsr_pkg::OP_TICK, 2'd0, 16'h0000);

		// largest step and jog, slow and fast periods
		set_config(8'd255, 8'd255, 8'd255, 8'd1, 8'd128);
		send_cmd(spsr_pkg::OP_SET, 2'd1, 16'hFFFF);
		send_cmd(spsr_pkg::OP_TICK, 2'd0, 16'h0000);
		send_cmd(spsr_pkg::OP_JOG_UP, 2'd2, 16'h0000);
		send_cmd(spsr_pkg::OP_JOG_UP, 2'd2, 16'h0000);

		// zero step, zero jog, zero periods
		set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		send_cmd(spsr_pkg::OP_SET, 2'd0, sb.pos[0] + 16'd1);
		send_cmd(spsr_pkg::OP_TICK, 2'd0, 16'h0000);
		send_cmd(spsr_pkg::OP_JOG_UP, 2'd1, 16'h0000);
		send_cmd(spsr_pkg::OP_TICK, 2'd0, 16'h0000);

		for (int ph = 0; ph < 5; ph++) begin
			rand_config();
			if (ph == 0)
				hold_req = 1'b1;
			if (ph == 4)
				idle_en = 1'b0;
			for (int i = 0; i < 80; i++)
				rand_cmd();
		end

		wait_idle();
		repeat (5) @(posedge clk);
		$display("Covered %0d requests, %0d results (%0d moving), %0d register writes",
		         sb.n_items, sb.n_results, sb.n_moving, n_cfg);
		$display("Settings ranged over zero, small and full-scale steps, jogs and periods");
		if (sb.errors == 0 && sb.expq.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
